[design/olpe_pkg.sv]
// Shared types and constants of the ordered list position engine.
// Depends on nothing; the interfaces, the sequencer and the top level refer to it by scoped names.
`default_nettype none

package olpe_pkg;

  localparam int CAPACITY  = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int WORD_W    = 32;
  localparam int CMD_W     = 3;
  localparam int POS_W     = 8;
  localparam int STATUS_W  = 3;
  localparam int FIELD6_W  = 6;
  localparam int POS_CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_SEARCH    = 3'd6,
    CMD_COUNT     = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_INS_WR,
    S_SHIFT_DOWN,
    S_SCAN,
    S_DONE
  } state_t;

  // What a newly accepted request turns into.
  typedef enum logic [2:0] {
    ACT_RESULT,
    ACT_APPEND,
    ACT_SHIFT_UP,
    ACT_TRIM,
    ACT_SHIFT_DOWN,
    ACT_SCAN
  } action_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD6_W-1:0] found_position;
    logic [FIELD6_W-1:0] entry_count;
  } result_t;

  // Fits a count-wide value into a 6-bit result field.
  function automatic logic [FIELD6_W-1:0] fit6(input logic [CNT_W-1:0] v);
    logic [FIELD6_W-1:0] r;
    r = '0;
    for (int i = 0; i < FIELD6_W; i++) begin
      if (i < CNT_W) begin
        r[i] = v[i];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/olpe_if.sv]
// Valid/ready channel interfaces for requests and results of the list engine.
// Depends on olpe_pkg for the field widths.
`default_nettype none

interface olpe_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [olpe_pkg::CMD_W-1:0]  cmd;
  logic [olpe_pkg::POS_W-1:0]  position;
  logic [olpe_pkg::WORD_W-1:0] item_value;

  modport source (output valid, output cmd, output position, output item_value,
                  input ready);
  modport sink   (input valid, input cmd, input position, input item_value,
                  output ready);
endinterface

interface olpe_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [olpe_pkg::STATUS_W-1:0] status;
  logic [olpe_pkg::FIELD6_W-1:0] found_position;
  logic [olpe_pkg::FIELD6_W-1:0] entry_count;

  modport source (output valid, output status, output found_position,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found_position,
                  input entry_count, output ready);
endinterface

`default_nettype wire

[design/olpe_ram.sv]
// Simple dual-port RAM, one write and one read port, registered read data.
// Generic; no package dependency.
`default_nettype none

module olpe_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/olpe_ctrl.sv]
// Sequencer of the list engine: decodes a request, then writes or trims the entry
// RAM directly or walks it to shift or scan it. Depends on olpe_pkg and olpe_if.
`default_nettype none

module olpe_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  olpe_cmd_if.sink                         cmd_ch,
  output logic                             mem_we,
  output logic [olpe_pkg::ADDR_W-1:0]      mem_waddr,
  output logic [olpe_pkg::WORD_W-1:0]      mem_wdata,
  output logic [olpe_pkg::ADDR_W-1:0]      mem_raddr,
  input  wire logic [olpe_pkg::WORD_W-1:0] mem_rdata,
  output logic                             res_valid,
  output olpe_pkg::result_t                res,
  input  wire logic                        res_taken
);

  localparam int AW = olpe_pkg::ADDR_W;
  localparam int CW = olpe_pkg::CNT_W;
  localparam int PW = olpe_pkg::POS_CMP_W;

  olpe_pkg::state_t state, state_next;

  logic [CW-1:0]                     len, len_next;
  logic [AW-1:0]                     ptr, ptr_next;
  logic [AW-1:0]                     slot;
  logic [olpe_pkg::WORD_W-1:0]       word;
  logic [olpe_pkg::STATUS_W-1:0]     res_status, res_status_next;
  logic [olpe_pkg::FIELD6_W-1:0]     res_found, res_found_next;

  logic                              accept;
  logic                              full, empty;
  logic [PW-1:0]                     pos_ext, len_ext;
  logic [AW-1:0]                     len_a, len_m1, pos_m1;
  olpe_pkg::action_t                 act;
  olpe_pkg::status_t                 dec_status;
  logic [AW-1:0]                     dec_slot;
  logic [CW-1:0]                     found_cnt;

  assign accept  = cmd_ch.valid && cmd_ch.ready;
  assign full    = (len == CW'(olpe_pkg::CAPACITY));
  assign empty   = (len == '0);
  assign pos_ext = PW'(cmd_ch.position);
  assign len_ext = PW'(len);
  assign len_a   = len[AW-1:0];
  assign len_m1  = len_a - AW'(1);
  assign pos_m1  = AW'(pos_ext - PW'(1));
  assign found_cnt = CW'(ptr) + CW'(1);

  // Decode of the request waiting at the input.
  always_comb begin
    act        = olpe_pkg::ACT_RESULT;
    dec_status = olpe_pkg::ST_OK;
    dec_slot   = '0;
    unique case (olpe_pkg::cmd_t'(cmd_ch.cmd)) inside
      olpe_pkg::CMD_INS_FRONT, olpe_pkg::CMD_INS_BACK, olpe_pkg::CMD_INS_AT: begin
        if (olpe_pkg::cmd_t'(cmd_ch.cmd) == olpe_pkg::CMD_INS_FRONT) begin
          dec_slot = '0;
        end else if (olpe_pkg::cmd_t'(cmd_ch.cmd) == olpe_pkg::CMD_INS_BACK) begin
          dec_slot = len_a;
        end else begin
          dec_slot = pos_m1;
        end
        if (olpe_pkg::cmd_t'(cmd_ch.cmd) == olpe_pkg::CMD_INS_AT &&
            (pos_ext == '0 || pos_ext > len_ext + PW'(1))) begin
          dec_status = olpe_pkg::ST_BADPOS;
        end else if (full) begin
          dec_status = olpe_pkg::ST_FULL;
        end else if (dec_slot == len_a) begin
          act = olpe_pkg::ACT_APPEND;
        end else begin
          act = olpe_pkg::ACT_SHIFT_UP;
        end
      end
      olpe_pkg::CMD_DEL_FRONT, olpe_pkg::CMD_DEL_BACK, olpe_pkg::CMD_DEL_AT: begin
        if (olpe_pkg::cmd_t'(cmd_ch.cmd) == olpe_pkg::CMD_DEL_FRONT) begin
          dec_slot = '0;
        end else if (olpe_pkg::cmd_t'(cmd_ch.cmd) == olpe_pkg::CMD_DEL_BACK) begin
          dec_slot = len_m1;
        end else begin
          dec_slot = pos_m1;
        end
        if (empty) begin
          dec_status = olpe_pkg::ST_EMPTY;
        end else if (olpe_pkg::cmd_t'(cmd_ch.cmd) == olpe_pkg::CMD_DEL_AT &&
                     (pos_ext == '0 || pos_ext > len_ext)) begin
          dec_status = olpe_pkg::ST_BADPOS;
        end else if (dec_slot == len_m1) begin
          act = olpe_pkg::ACT_TRIM;
        end else begin
          act = olpe_pkg::ACT_SHIFT_DOWN;
        end
      end
      olpe_pkg::CMD_SEARCH: begin
        if (empty) begin
          dec_status = olpe_pkg::ST_EMPTY;
        end else begin
          act = olpe_pkg::ACT_SCAN;
        end
      end
      default: begin
        act = olpe_pkg::ACT_RESULT;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      olpe_pkg::S_IDLE: begin
        if (accept) begin
          unique case (act)
            olpe_pkg::ACT_SHIFT_UP:   state_next = olpe_pkg::S_SHIFT_UP;
            olpe_pkg::ACT_SHIFT_DOWN: state_next = olpe_pkg::S_SHIFT_DOWN;
            olpe_pkg::ACT_SCAN:       state_next = olpe_pkg::S_SCAN;
            default:                  state_next = olpe_pkg::S_DONE;
          endcase
        end
      end
      olpe_pkg::S_SHIFT_UP: begin
        if (ptr == slot) begin
          state_next = olpe_pkg::S_INS_WR;
        end
      end
      olpe_pkg::S_INS_WR: begin
        state_next = olpe_pkg::S_DONE;
      end
      olpe_pkg::S_SHIFT_DOWN: begin
        if (ptr == len_m1) begin
          state_next = olpe_pkg::S_DONE;
        end
      end
      olpe_pkg::S_SCAN: begin
        if (mem_rdata == word || ptr == len_m1) begin
          state_next = olpe_pkg::S_DONE;
        end
      end
      olpe_pkg::S_DONE: begin
        if (res_taken) begin
          state_next = olpe_pkg::S_IDLE;
        end
      end
      default: state_next = olpe_pkg::S_IDLE;
    endcase
  end

  // Memory accesses and register updates. A read issued at ptr returns next
  // cycle, when a shift writes the word one slot up or down or a scan compares it.
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = ptr;
    mem_wdata       = mem_rdata;
    mem_raddr       = ptr;
    ptr_next        = ptr;
    len_next        = len;
    res_status_next = res_status;
    res_found_next  = res_found;
    unique case (state)
      olpe_pkg::S_IDLE: begin
        if (accept) begin
          res_status_next = dec_status;
          res_found_next  = '0;
          unique case (act)
            olpe_pkg::ACT_APPEND: begin
              mem_we    = 1'b1;
              mem_waddr = dec_slot;
              mem_wdata = cmd_ch.item_value;
              len_next  = len + CW'(1);
            end
            olpe_pkg::ACT_SHIFT_UP: begin
              mem_raddr = len_m1;
              ptr_next  = len_m1;
            end
            olpe_pkg::ACT_TRIM: begin
              len_next = len - CW'(1);
            end
            olpe_pkg::ACT_SHIFT_DOWN: begin
              mem_raddr = dec_slot + AW'(1);
              ptr_next  = dec_slot + AW'(1);
            end
            olpe_pkg::ACT_SCAN: begin
              mem_raddr = '0;
              ptr_next  = '0;
            end
            default: begin
              len_next = len;
            end
          endcase
        end
      end
      olpe_pkg::S_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_waddr = ptr + AW'(1);
        if (ptr != slot) begin
          mem_raddr = ptr - AW'(1);
          ptr_next  = ptr - AW'(1);
        end
      end
      olpe_pkg::S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = slot;
        mem_wdata = word;
        len_next  = len + CW'(1);
      end
      olpe_pkg::S_SHIFT_DOWN: begin
        mem_we    = 1'b1;
        mem_waddr = ptr - AW'(1);
        if (ptr == len_m1) begin
          len_next = len - CW'(1);
        end else begin
          mem_raddr = ptr + AW'(1);
          ptr_next  = ptr + AW'(1);
        end
      end
      olpe_pkg::S_SCAN: begin
        if (mem_rdata == word) begin
          res_status_next = olpe_pkg::ST_OK;
          res_found_next  = olpe_pkg::fit6(found_cnt);
        end else if (ptr == len_m1) begin
          res_status_next = olpe_pkg::ST_NOTFOUND;
        end else begin
          mem_raddr = ptr + AW'(1);
          ptr_next  = ptr + AW'(1);
        end
      end
      olpe_pkg::S_DONE: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= olpe_pkg::S_IDLE;
      len   <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    if (accept) begin
      slot <= dec_slot;
      word <= cmd_ch.item_value;
    end
  end

  assign cmd_ch.ready       = (state == olpe_pkg::S_IDLE) && !rst;
  assign res_valid          = (state == olpe_pkg::S_DONE);
  assign res.status         = res_status;
  assign res.found_position = res_found;
  assign res.entry_count    = olpe_pkg::fit6(len);

endmodule

`default_nettype wire

[design/ordered_list_position_engine.sv]
// Ordered list engine: count, errors, append and delete of the last entry need
// no walk of the entry RAM; insert and delete at a slot shift the tail of the list
// up or down, and a search scans from the front to a hit or the last entry, with
// at most one RAM read and one write per cycle. The result sits in an output register.
// Reset clears the entry count and handshake state; the entry RAM is not cleared.
`default_nettype none

module ordered_list_position_engine (
  input  wire logic  clk,
  input  wire logic  rst,
  olpe_cmd_if.sink   cmd_ch,
  olpe_rsp_if.source rsp_ch
);

  logic                          mem_we;
  logic [olpe_pkg::ADDR_W-1:0]   mem_waddr;
  logic [olpe_pkg::WORD_W-1:0]   mem_wdata;
  logic [olpe_pkg::ADDR_W-1:0]   mem_raddr;
  logic [olpe_pkg::WORD_W-1:0]   mem_rdata;
  logic                          res_valid;
  olpe_pkg::result_t             res;
  logic                          res_taken;
  logic                          out_valid;
  olpe_pkg::result_t             out_data;

  olpe_ram #(
    .DATA_W (olpe_pkg::WORD_W),
    .DEPTH  (olpe_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  olpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_ch    (cmd_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_taken)
  );

  // The output register frees the sequencer as soon as a result is parked.
  assign res_taken = res_valid && (!out_valid || rsp_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_taken) begin
      out_valid <= 1'b1;
    end else if (rsp_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_data <= res;
    end
  end

  assign rsp_ch.valid          = out_valid;
  assign rsp_ch.status         = out_data.status;
  assign rsp_ch.found_position = out_data.found_position;
  assign rsp_ch.entry_count    = out_data.entry_count;

endmodule

`default_nettype wire
